FILE: sv/pmou_pkg.sv
// ============================================================================
// pmou_pkg
// shared types and constants of the pipe outflow update pipeline
// ============================================================================
package pmou_pkg;

    localparam int LANES      = 4;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;
    localparam int FLOW_W     = 31;
    localparam int TOTAL_W    = 33;
    localparam int DEN_W      = 49;
    localparam int PROD_W     = 59;
    localparam int CMP_W      = 65;
    localparam int OUT_W      = 16;
    localparam int DIV_BITS   = 16;
    localparam int NUM_SHIFT  = 12;

    localparam logic [31:0]        DAMP_BIAS = 32'd16384;
    localparam logic signed [51:0] RISE_BIAS = 52'sd524288;
    localparam logic [OUT_W-1:0]   SAT_MAX   = '1;

    localparam logic [CFG_W-1:0] TIME_STEP_RST    = 16'd82;
    localparam logic [CFG_W-1:0] GRAVITY_RST      = 16'd2509;
    localparam logic [CFG_W-1:0] FLOW_DAMPING_RST = 16'd32768;

    typedef enum logic [IDX_W-1:0] {
        REG_TIME_STEP    = 2'd0,
        REG_GRAVITY      = 2'd1,
        REG_FLOW_DAMPING = 2'd2
    } pmou_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] time_step;
        logic [CFG_W-1:0] gravity;
        logic [CFG_W-1:0] flow_damping;
    } pmou_cfg_t;

    typedef struct packed {
        logic                           valid;
        logic [15:0]                    water;
        logic [DEN_W-1:0]               den;
        logic [LANES-1:0][FLOW_W-1:0]   flow;
        logic [LANES-1:0][PROD_W-1:0]   prod;
    } pmou_prod_t;

endpackage

FILE: sv/pmou_cfg_regs.sv
// ============================================================================
// pmou_cfg_regs
// configuration registers: time step, gravity and flow damping
// ============================================================================
module pmou_cfg_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [pmou_pkg::IDX_W-1:0] wr_index,
    input  logic [pmou_pkg::CFG_W-1:0] wr_data,
    output pmou_pkg::pmou_cfg_t      cfg
);
    import pmou_pkg::*;

    pmou_cfg_t cfg_reg;
    pmou_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TIME_STEP:    cfg_next.time_step    = wr_data;
                REG_GRAVITY:      cfg_next.gravity      = wr_data;
                REG_FLOW_DAMPING: cfg_next.flow_damping = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step    <= TIME_STEP_RST;
            cfg_reg.gravity      <= GRAVITY_RST;
            cfg_reg.flow_damping <= FLOW_DAMPING_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/pmou_flow_calc.sv
// ============================================================================
// pmou_flow_calc
// five-stage front: level differences, rise and damping products, clamped
// flows, their total, and the scaling products fed to the divider
// ============================================================================
module pmou_flow_calc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pmou_pkg::pmou_cfg_t    cfg,
    input  logic                   in_valid,
    input  logic signed [15:0]     cell_height,
    input  logic [15:0]            cell_water,
    input  logic signed [17:0]     level_east,
    input  logic signed [17:0]     level_north,
    input  logic signed [17:0]     level_west,
    input  logic signed [17:0]     level_south,
    input  logic [3:0]             neighbour_mask,
    input  logic [15:0]            old_flow_east,
    input  logic [15:0]            old_flow_north,
    input  logic [15:0]            old_flow_west,
    input  logic [15:0]            old_flow_south,
    output pmou_pkg::pmou_prod_t   prod_out
);
    import pmou_pkg::*;

    // stage 1
    logic                     v1_reg;
    logic signed [18:0]       d1_reg [LANES];
    logic [31:0]              fac1_reg;
    logic [31:0]              op1_reg [LANES];
    logic [LANES-1:0]         mask1_reg;
    logic [15:0]              water1_reg;

    // stage 2
    logic                     v2_reg;
    logic signed [51:0]       df2_reg [LANES];
    logic [16:0]              p2_reg [LANES];
    logic [LANES-1:0]         mask2_reg;
    logic [15:0]              water2_reg;

    // stage 3
    logic                     v3_reg;
    logic [FLOW_W-1:0]        flow3_reg [LANES];
    logic [15:0]              water3_reg;

    // stage 4
    logic                     v4_reg;
    logic [FLOW_W-1:0]        flow4_reg [LANES];
    logic [TOTAL_W-1:0]       total4_reg;
    logic [15:0]              water4_reg;

    // stage 5
    logic                         v5_reg;
    logic [15:0]                  water5_reg;
    logic [DEN_W-1:0]             den5_reg;
    logic [LANES-1:0][FLOW_W-1:0] flow5_reg;
    logic [LANES-1:0][PROD_W-1:0] prod5_reg;

    logic signed [17:0]       own;
    logic signed [17:0]       level [LANES];
    logic [15:0]              old_flow [LANES];
    logic signed [18:0]       d_next [LANES];
    logic [31:0]              op_next [LANES];
    logic signed [51:0]       df_next [LANES];
    logic [16:0]              p_next [LANES];
    logic [31:0]              p_sum [LANES];
    logic signed [51:0]       r_sum [LANES];
    logic signed [32:0]       f_sum [LANES];
    logic [FLOW_W-1:0]        flow_next [LANES];
    logic [TOTAL_W-1:0]       total_next;

    assign level[0]    = level_east;
    assign level[1]    = level_north;
    assign level[2]    = level_west;
    assign level[3]    = level_south;
    assign old_flow[0] = old_flow_east;
    assign old_flow[1] = old_flow_north;
    assign old_flow[2] = old_flow_west;
    assign old_flow[3] = old_flow_south;

    assign own = 18'(cell_height) + $signed({2'b00, cell_water});

    always_comb
    begin
        total_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            d_next[i]  = 19'(own) - 19'(level[i]);
            op_next[i] = 32'(old_flow[i]) * 32'(cfg.flow_damping);

            df_next[i] = 52'(d1_reg[i]) * $signed({20'b0, fac1_reg});
            p_sum[i]   = op1_reg[i] + DAMP_BIAS;
            p_next[i]  = p_sum[i][31:15];

            // round half up, then add the damped old flow
            r_sum[i]   = df2_reg[i] + RISE_BIAS;
            f_sum[i]   = 33'($signed(r_sum[i][51:20])) + $signed({16'b0, p2_reg[i]});
            if (mask2_reg[i] && !f_sum[i][32] && (f_sum[i] != '0))
                flow_next[i] = f_sum[i][FLOW_W-1:0];
            else
                flow_next[i] = '0;

            total_next = total_next + TOTAL_W'(flow3_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fac1_reg   <= 32'(cfg.time_step) * 32'(cfg.gravity);
        mask1_reg  <= neighbour_mask;
        water1_reg <= cell_water;
        mask2_reg  <= mask1_reg;
        water2_reg <= water1_reg;
        water3_reg <= water2_reg;
        water4_reg <= water3_reg;
        total4_reg <= total_next;
        water5_reg <= water4_reg;
        den5_reg   <= DEN_W'(total4_reg) * DEN_W'(cfg.time_step);
        for (int i = 0; i < LANES; i++)
        begin
            d1_reg[i]    <= d_next[i];
            op1_reg[i]   <= op_next[i];
            df2_reg[i]   <= df_next[i];
            p2_reg[i]    <= p_next[i];
            flow3_reg[i] <= flow_next[i];
            flow4_reg[i] <= flow3_reg[i];
            flow5_reg[i] <= flow4_reg[i];
            prod5_reg[i] <= PROD_W'(flow4_reg[i])
                            * PROD_W'({water4_reg, NUM_SHIFT'(0)});
        end
    end

    assign prod_out = '{valid: v5_reg, water: water5_reg, den: den5_reg,
                        flow: flow5_reg, prod: prod5_reg};

endmodule

FILE: sv/pmou_scale_div.sv
// ============================================================================
// pmou_scale_div
// pipelined restoring divider that scales the four flows by (water << 12) /
// (total * time step) if below one, one quotient bit per stage, saturating
// ============================================================================
module pmou_scale_div (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  pmou_pkg::pmou_prod_t                         prod_in,
    output logic                                         out_valid,
    output logic [pmou_pkg::LANES-1:0][pmou_pkg::OUT_W-1:0] flow_out
);
    import pmou_pkg::*;

    logic                            v_reg     [0:DIV_BITS];
    logic                            scale_reg [0:DIV_BITS];
    logic [DEN_W-1:0]                den_reg   [0:DIV_BITS];
    logic [LANES-1:0]                sat_reg   [0:DIV_BITS];
    logic [LANES-1:0][OUT_W-1:0]     fsat_reg  [0:DIV_BITS];
    logic [LANES-1:0][PROD_W-1:0]    rem_reg   [0:DIV_BITS];
    logic [LANES-1:0][OUT_W-1:0]     q_reg     [0:DIV_BITS];

    logic                            vo_reg;
    logic [LANES-1:0][OUT_W-1:0]     res_reg;
    logic [LANES-1:0][OUT_W-1:0]     res_next;

    logic [CMP_W-1:0]                num_ext;
    logic [CMP_W-1:0]                sat_lim;
    logic                            scale_next;
    logic [LANES-1:0]                sat_next;
    logic [LANES-1:0][OUT_W-1:0]     fsat_next;

    // entry: scale decision, quotient overflow check, unscaled saturation
    assign num_ext    = CMP_W'({prod_in.water, NUM_SHIFT'(0)});
    assign scale_next = (prod_in.den != '0) && (num_ext < CMP_W'(prod_in.den));
    assign sat_lim    = {prod_in.den, DIV_BITS'(0)};

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sat_next[l] = CMP_W'(prod_in.prod[l]) >= sat_lim;
            if (prod_in.flow[l] > FLOW_W'(SAT_MAX))
                fsat_next[l] = SAT_MAX;
            else
                fsat_next[l] = prod_in.flow[l][OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= prod_in.valid;
    end

    always_ff @(posedge clk)
    begin
        scale_reg[0] <= scale_next;
        den_reg[0]   <= prod_in.den;
        sat_reg[0]   <= sat_next;
        fsat_reg[0]  <= fsat_next;
        rem_reg[0]   <= prod_in.prod;
        q_reg[0]     <= '0;
    end

    for (genvar j = 1; j <= DIV_BITS; j++)
    begin : g_step
        localparam int K = DIV_BITS - j;

        logic [CMP_W-1:0]             trial;
        logic [LANES-1:0]             take;
        logic [LANES-1:0][PROD_W-1:0] rem_next;
        logic [LANES-1:0][OUT_W-1:0]  q_next;

        assign trial = CMP_W'(den_reg[j-1]) << K;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                take[l] = CMP_W'(rem_reg[j-1][l]) >= trial;
                if (take[l])
                begin
                    rem_next[l] = rem_reg[j-1][l] - trial[PROD_W-1:0];
                    q_next[l]   = q_reg[j-1][l] | (OUT_W'(1) << K);
                end
                else
                begin
                    rem_next[l] = rem_reg[j-1][l];
                    q_next[l]   = q_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            scale_reg[j] <= scale_reg[j-1];
            den_reg[j]   <= den_reg[j-1];
            sat_reg[j]   <= sat_reg[j-1];
            fsat_reg[j]  <= fsat_reg[j-1];
            rem_reg[j]   <= rem_next;
            q_reg[j]     <= q_next;
        end
    end

    // result select
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (!scale_reg[DIV_BITS])
                res_next[l] = fsat_reg[DIV_BITS][l];
            else if (sat_reg[DIV_BITS][l])
                res_next[l] = SAT_MAX;
            else
                res_next[l] = q_reg[DIV_BITS][l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= v_reg[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vo_reg;
    assign flow_out  = res_reg;

endmodule

FILE: sv/pipe_model_outflow_update_top.sv
// ============================================================================
// pipe_model_outflow_update_top
// virtual-pipe outflow update for one grid cell per clock
// ============================================================================
// throughput: one cell per cycle; busy stays low and start is always taken
// depth is set by the 16-step restoring divider of the outflow scaling
// the receiver cannot stall, so done is a one-cycle strobe per transfer
// reset empties the pipeline and loads the default time step, gravity, damping
module pipe_model_outflow_update_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  cell_height,
    input  logic [15:0]         cell_water,
    input  logic signed [17:0]  level_east,
    input  logic signed [17:0]  level_north,
    input  logic signed [17:0]  level_west,
    input  logic signed [17:0]  level_south,
    input  logic [3:0]          neighbour_mask,
    input  logic [15:0]         old_flow_east,
    input  logic [15:0]         old_flow_north,
    input  logic [15:0]         old_flow_west,
    input  logic [15:0]         old_flow_south,
    output logic                done,
    output logic [15:0]         new_flow_east,
    output logic [15:0]         new_flow_north,
    output logic [15:0]         new_flow_west,
    output logic [15:0]         new_flow_south,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [pmou_pkg::IDX_W-1:0] cfg_index,
    input  logic [pmou_pkg::CFG_W-1:0] cfg_data
);
    import pmou_pkg::*;

    pmou_cfg_t                   cfg;
    pmou_prod_t                  prod;
    logic [LANES-1:0][OUT_W-1:0] flow_out;
    logic                        in_xfer;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_xfer   = start && !busy;

    pmou_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pmou_flow_calc u_calc (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_xfer),
        .cell_height    (cell_height),
        .cell_water     (cell_water),
        .level_east     (level_east),
        .level_north    (level_north),
        .level_west     (level_west),
        .level_south    (level_south),
        .neighbour_mask (neighbour_mask),
        .old_flow_east  (old_flow_east),
        .old_flow_north (old_flow_north),
        .old_flow_west  (old_flow_west),
        .old_flow_south (old_flow_south),
        .prod_out       (prod)
    );

    pmou_scale_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod_in   (prod),
        .out_valid (done),
        .flow_out  (flow_out)
    );

    assign new_flow_east  = flow_out[0];
    assign new_flow_north = flow_out[1];
    assign new_flow_west  = flow_out[2];
    assign new_flow_south = flow_out[3];

endmodule

FILE: sim/testbench.sv
// ============================================================================
// testbench
// checks the pipe outflow update pipeline against a cycle-free predictor of
// the four new outflows; cells stream in with random gaps, results are
// matched in order as they strobe out, and the time step, gravity and damping
// registers are changed between phases while the pipeline is empty
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pmou_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES          = 8;
    localparam int RANDOM_PHASE    = 6;
    localparam int ITEMS_PER_PHASE = 232;

    typedef logic [LANES-1:0][OUT_W-1:0] flow_t;

    typedef struct packed {
        logic [15:0]            height;
        logic [15:0]            water;
        logic [LANES-1:0][17:0] level;
        logic [LANES-1:0]       mask;
        logic [LANES-1:0][15:0] old_flow;
    } cell_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] cell_height = '0;
    logic [15:0] cell_water = '0;
    logic [17:0] level_east = '0;
    logic [17:0] level_north = '0;
    logic [17:0] level_west = '0;
    logic [17:0] level_south = '0;
    logic [3:0]  neighbour_mask = '0;
    logic [15:0] old_flow_east = '0;
    logic [15:0] old_flow_north = '0;
    logic [15:0] old_flow_west = '0;
    logic [15:0] old_flow_south = '0;
    logic        done;
    logic [15:0] new_flow_east;
    logic [15:0] new_flow_north;
    logic [15:0] new_flow_west;
    logic [15:0] new_flow_south;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic [CFG_W-1:0] cur_time_step = TIME_STEP_RST;
    logic [CFG_W-1:0] cur_gravity   = GRAVITY_RST;
    logic [CFG_W-1:0] cur_damping   = FLOW_DAMPING_RST;

    logic [CFG_W-1:0] step_set [PHASES] =
        '{16'd82, 16'd1, 16'hFFFF, 16'd0, 16'd4096, 16'd82, 16'd0, 16'd0};
    logic [CFG_W-1:0] gravity_set [PHASES] =
        '{16'd2509, 16'd0, 16'hFFFF, 16'd2509, 16'd2509, 16'd256, 16'd0, 16'd0};
    logic [CFG_W-1:0] damping_set [PHASES] =
        '{16'd32768, 16'd0, 16'hFFFF, 16'd32768, 16'd32768, 16'd16384, 16'd0, 16'd0};

    string lane_name [LANES] =
        '{"new_flow_east", "new_flow_north", "new_flow_west", "new_flow_south"};

    cell_t pending_cells[$];
    flow_t expected_flows[$];
    cell_t on_port;
    int    wait_cycles = 0;
    bit    no_idle = 1'b0;
    int    errors = 0;

    pipe_model_outflow_update_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cell_height    (cell_height),
        .cell_water     (cell_water),
        .level_east     (level_east),
        .level_north    (level_north),
        .level_west     (level_west),
        .level_south    (level_south),
        .neighbour_mask (neighbour_mask),
        .old_flow_east  (old_flow_east),
        .old_flow_north (old_flow_north),
        .old_flow_west  (old_flow_west),
        .old_flow_south (old_flow_south),
        .done           (done),
        .new_flow_east  (new_flow_east),
        .new_flow_north (new_flow_north),
        .new_flow_west  (new_flow_west),
        .new_flow_south (new_flow_south),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic flow_t predict_outflow(cell_t c);
        longint own;
        longint factor;
        longint rise;
        longint damped;
        longint f;
        longint unsigned flow [LANES];
        longint unsigned total;
        longint unsigned num;
        longint unsigned den;
        flow_t r;
        own    = longint'($signed(c.height)) + longint'(c.water);
        factor = longint'(cur_time_step) * longint'(cur_gravity);
        total  = 0;
        for (int i = 0; i < LANES; i++)
        begin
            flow[i] = 0;
            if (c.mask[i])
            begin
                rise   = ((own - longint'($signed(c.level[i]))) * factor + 64'sd524288) >>> 20;
                damped = (longint'(c.old_flow[i]) * longint'(cur_damping) + 64'sd16384) >>> 15;
                f      = damped + rise;
                flow[i] = (f > 0) ? longint'(f) : 0;
            end
            total += flow[i];
        end
        if (total > 0)
        begin
            num = longint'(c.water) << NUM_SHIFT;
            den = total * longint'(cur_time_step);
            if (den != 0 && num < den)
            begin
                for (int i = 0; i < LANES; i++)
                    flow[i] = (flow[i] * num) / den;
            end
        end
        for (int i = 0; i < LANES; i++)
            r[i] = (flow[i] > 65535) ? SAT_MAX : flow[i][OUT_W-1:0];
        return r;
    endfunction

    function automatic cell_t make_cell(logic [15:0] h, logic [15:0] w, logic [17:0] lvl,
                                        logic [3:0] m, logic [15:0] old);
        cell_t c;
        c.height = h;
        c.water  = w;
        c.mask   = m;
        for (int i = 0; i < LANES; i++)
        begin
            c.level[i]    = lvl;
            c.old_flow[i] = old;
        end
        return c;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        longint own;
        c.height = 16'($urandom_range(0, 65535));
        c.water  = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 255))
                                                : 16'($urandom_range(0, 65535));
        c.mask   = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
        own      = longint'($signed(c.height)) + longint'(c.water);
        for (int i = 0; i < LANES; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                c.level[i] = 18'($urandom_range(0, 262143));
            else
                c.level[i] = 18'(own + longint'($urandom_range(0, 8191)) - 64'sd4096);
            case ($urandom_range(0, 3))
                0: c.old_flow[i] = '0;
                1: c.old_flow[i] = 16'($urandom_range(0, 1023));
                default: c.old_flow[i] = 16'($urandom_range(0, 65535));
            endcase
        end
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            wait_cycles = 0;
        end
        else
        begin
            if (start && !busy)
                expected_flows.push_back(predict_outflow(on_port));
            if (!(start && busy))
            begin
                if (pending_cells.size() != 0 && wait_cycles == 0)
                begin
                    on_port = pending_cells.pop_front();
                    cell_height    <= on_port.height;
                    cell_water     <= on_port.water;
                    level_east     <= on_port.level[0];
                    level_north    <= on_port.level[1];
                    level_west     <= on_port.level[2];
                    level_south    <= on_port.level[3];
                    neighbour_mask <= on_port.mask;
                    old_flow_east  <= on_port.old_flow[0];
                    old_flow_north <= on_port.old_flow[1];
                    old_flow_west  <= on_port.old_flow[2];
                    old_flow_south <= on_port.old_flow[3];
                    start <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        no_idle = !no_idle;
                    wait_cycles = no_idle ? 0 : int'($urandom_range(0, 19));
                end
                else
                begin
                    start <= 1'b0;
                    if (wait_cycles > 0)
                        wait_cycles--;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        flow_t got;
        flow_t want;
        if (rst_n && done)
        begin
            got = {new_flow_south, new_flow_west, new_flow_north, new_flow_east};
            if (expected_flows.size() == 0)
            begin
                $error("result transfer with no cell outstanding");
                errors++;
            end
            else
            begin
                want = expected_flows.pop_front();
                for (int i = 0; i < LANES; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $error("%s expected %0d actual %0d", lane_name[i], want[i], got[i]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TIME_STEP:    cur_time_step = val;
            REG_GRAVITY:      cur_gravity = val;
            REG_FLOW_DAMPING: cur_damping = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cells.size() != 0 || start || expected_flows.size() != 0);
    endtask

    initial
    begin : stimulus
        cell_t c;
        logic [CFG_W-1:0] ts;
        logic [CFG_W-1:0] gv;
        logic [CFG_W-1:0] dm;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        pending_cells.push_back(make_cell(16'd0, 16'd0, 18'd0, 4'h0, 16'd0));
        pending_cells.push_back(make_cell(16'd0, 16'd0, 18'd0, 4'hF, 16'd0));
        pending_cells.push_back(make_cell(16'h8000, 16'd0, 18'h1FFFF, 4'hF, 16'hFFFF));
        pending_cells.push_back(make_cell(16'h7FFF, 16'hFFFF, 18'h20000, 4'hF, 16'hFFFF));
        pending_cells.push_back(make_cell(16'h7FFF, 16'hFFFF, 18'h20000, 4'h0, 16'hFFFF));
        pending_cells.push_back(make_cell(16'h8000, 16'hFFFF, 18'h07FFF, 4'hA, 16'hFFFF));
        pending_cells.push_back(make_cell(16'd100, 16'd200, 18'd300, 4'hF, 16'd1000));
        pending_cells.push_back(make_cell(16'd0, 16'd1, 18'd1, 4'hF, 16'hFFFF));
        pending_cells.push_back(make_cell(16'd0, 16'd16, -18'sd25600, 4'hF, 16'd0));
        pending_cells.push_back(make_cell(16'd0, 16'hFFFF, 18'h1FFFF, 4'hF, 16'h8000));
        for (int i = 0; i < LANES; i++)
            pending_cells.push_back(make_cell(16'd0, 16'd256, -18'sd2560, 4'(1 << i), 16'd0));
        for (int m = 0; m < 6; m++)
        begin
            c = random_cell();
            c.mask = 4'($urandom_range(0, 15));
            c.level[m % LANES] = 18'h20000;
            c.old_flow[(m + 1) % LANES] = 16'hFFFF;
            pending_cells.push_back(c);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                wait_drained();
                ts = (phase >= RANDOM_PHASE) ? CFG_W'($urandom_range(1, 65535))
                                             : step_set[phase];
                gv = (phase >= RANDOM_PHASE) ? CFG_W'($urandom_range(0, 65535))
                                             : gravity_set[phase];
                dm = (phase >= RANDOM_PHASE) ? CFG_W'($urandom_range(0, 65535))
                                             : damping_set[phase];
                @(posedge clk);
                write_reg(REG_TIME_STEP, ts);
                write_reg(REG_GRAVITY, gv);
                write_reg(REG_FLOW_DAMPING, dm);
                write_reg(REG_SPARE, CFG_W'($urandom_range(0, 65535)));
                cfg_valid <= 1'b0;
                @(negedge clk);
            end
            repeat (ITEMS_PER_PHASE) pending_cells.push_back(random_cell());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[pipe_model_outflow_update_top] OK");
        else
            $display("[pipe_model_outflow_update_top] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[pipe_model_outflow_update_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/pmou_pkg.sv
sv/pmou_cfg_regs.sv
sv/pmou_flow_calc.sv
sv/pmou_scale_div.sv
sv/pipe_model_outflow_update_top.sv
sim/testbench.sv
